// ===== hw/rtl/rse_pkg.sv =====
package rse_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned QUO_W  = DATA_W + 1;
  localparam int unsigned NUM_W  = 33;
  localparam logic [DATA_W-1:0] BETA_RESET = 16'd4096;
  localparam logic [DATA_W-1:0] PROB_MAX   = 16'hFFFF;
  localparam logic signed [DATA_W-1:0] MAX_RESET = 16'sh8000;

  // exp(-n) in Q.16, n = 0..11
  function automatic logic [16:0] exp_int(input logic [3:0] n);
    logic [16:0] v;
    begin
      case (n)
        4'd0:    v = 17'd65536;
        4'd1:    v = 17'd24109;
        4'd2:    v = 17'd8869;
        4'd3:    v = 17'd3263;
        4'd4:    v = 17'd1200;
        4'd5:    v = 17'd442;
        4'd6:    v = 17'd162;
        4'd7:    v = 17'd60;
        4'd8:    v = 17'd22;
        4'd9:    v = 17'd8;
        4'd10:   v = 17'd3;
        4'd11:   v = 17'd1;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

  // exp(-k/16) in Q.16, k = 0..16
  function automatic logic [16:0] exp_frac(input logic [4:0] k);
    logic [16:0] v;
    begin
      case (k)
        5'd0:    v = 17'd65536;
        5'd1:    v = 17'd61565;
        5'd2:    v = 17'd57835;
        5'd3:    v = 17'd54331;
        5'd4:    v = 17'd51039;
        5'd5:    v = 17'd47947;
        5'd6:    v = 17'd45042;
        5'd7:    v = 17'd42313;
        5'd8:    v = 17'd39750;
        5'd9:    v = 17'd37341;
        5'd10:   v = 17'd35079;
        5'd11:   v = 17'd32954;
        5'd12:   v = 17'd30957;
        5'd13:   v = 17'd29081;
        5'd14:   v = 17'd27319;
        5'd15:   v = 17'd25665;
        5'd16:   v = 17'd24109;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== hw/rtl/rse_exp.sv =====
module rse_exp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rse_pkg::DATA_W-1:0] diff,
  input  logic [rse_pkg::DATA_W-1:0] beta,
  output logic                      busy,
  output logic [rse_pkg::DATA_W-1:0] exp_val
);
  import rse_pkg::*;

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_MUL  = 4'b0010,
    E_FRAC = 4'b0100,
    E_PROD = 4'b1000
  } exp_state_t;

  exp_state_t          state_r, state_nxt;
  logic [PROD_W-1:0]   p_r;
  logic [DATA_W-1:0]   m_r;
  logic [DATA_W-1:0]   d_r;
  logic [3:0]          cnt_r;
  logic [16:0]         frac_r;
  logic [3:0]          nidx_r;
  logic                zero_r;
  logic [DATA_W-1:0]   e_r;

  logic [DATA_W:0]     step_sum;
  logic [11:0]         n_w;
  logic [16:0]         fk, fk1, fdiff, frac_w;
  logic [20:0]         fmul;
  logic [33:0]         prod;

  always_comb begin
    step_sum = {1'b0, p_r[PROD_W-1:DATA_W]} + (m_r[0] ? {1'b0, d_r} : '0);
    n_w      = p_r[31:20];
    fk       = exp_frac({1'b0, p_r[19:16]});
    fk1      = exp_frac({1'b0, p_r[19:16]} + 5'd1);
    fdiff    = fk - fk1;
    fmul     = fdiff * {17'd0, p_r[15:12]};
    frac_w   = fk - {4'd0, fmul[16:4]};
    prod     = {17'd0, exp_int(nidx_r)} * {17'd0, frac_r} + 34'd32768;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      E_IDLE:  if (start) state_nxt = E_MUL;
      E_MUL:   if (cnt_r == 4'd15) state_nxt = E_FRAC;
      E_FRAC:  state_nxt = E_PROD;
      E_PROD:  state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      E_IDLE: begin
        p_r   <= '0;
        m_r   <= beta;
        d_r   <= diff;
        cnt_r <= '0;
      end
      E_MUL: begin
        // one multiplier bit per cycle, product shifts right
        p_r   <= {step_sum, p_r[DATA_W-1:1]};
        m_r   <= m_r >> 1;
        cnt_r <= cnt_r + 4'd1;
      end
      E_FRAC: begin
        frac_r <= frac_w;
        nidx_r <= n_w[3:0];
        zero_r <= (n_w >= 12'd12);
      end
      E_PROD: begin
        if (zero_r) e_r <= '0;
        else if (prod[33:16] > {2'b0, PROB_MAX}) e_r <= PROB_MAX;
        else e_r <= prod[31:16];
      end
      default: ;
    endcase
  end

  assign busy    = (state_r != E_IDLE);
  assign exp_val = e_r;

endmodule

// ===== hw/rtl/rse_div.sv =====
module rse_div #(
  parameter int unsigned SUM_W = 22
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rse_pkg::DATA_W-1:0] exp_val,
  input  logic [SUM_W-1:0]          sum,
  output logic                      busy,
  output logic [rse_pkg::DATA_W-1:0] prob
);
  import rse_pkg::*;

  logic              busy_r;
  logic [4:0]        cnt_r;
  logic [SUM_W-1:0]  rem_r;
  logic [QUO_W-1:0]  low_r;
  logic [QUO_W-1:0]  quo_r;
  logic [NUM_W-1:0]  num;
  logic [SUM_W:0]    rs;
  logic              ge;

  always_comb begin
    // rounded numerator: e * 2^16 + sum / 2
    num = {1'b0, exp_val, 16'd0} + NUM_W'(sum >> 1);
    rs  = {rem_r, low_r[QUO_W-1]};
    ge  = (rs >= {1'b0, sum});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (!busy_r) begin
      busy_r <= start;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(QUO_W - 1)) busy_r <= 1'b0;
    end
  end

  // quotient fits 17 bits since e <= sum, so the top bits start as the remainder
  always_ff @(posedge clk) begin
    if (!busy_r) begin
      if (start) begin
        rem_r <= SUM_W'(num[NUM_W-1:QUO_W]);
        low_r <= num[QUO_W-1:0];
      end
    end else begin
      rem_r <= ge ? SUM_W'(rs - {1'b0, sum}) : rs[SUM_W-1:0];
      low_r <= low_r << 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign prob = quo_r[QUO_W-1] ? PROB_MAX : quo_r[DATA_W-1:0];

endmodule

// ===== hw/rtl/row_softmax_engine_top.sv =====
// Row softmax engine. Logits (signed Q7.8) stream in one per cycle and are
// stored up to MAX_ROW_LEN per row; extras are dropped and every result of that
// row carries the truncation flag in out_tuser. The transfer with in_tlast ends
// the row: for each stored element the block then forms exp(-(max-x)*beta) in
// Q0.16 (bit-serial 16x16 multiply, then table lookup and interpolation)
// and adds it to the row sum, then divides each exponential by the
// sum with a bit-serial restoring divider; a result waits while the
// receiver stalls. The input stays closed until the last probability of
// the row has been registered for output. Probabilities leave in arrival
// order, with out_tlast on the last. beta_gain (Q4.12, reset 1.0) is
// written through the cfg port; the user must write it only between rows,
// as the block itself does not enforce this.
module row_softmax_engine_top #(
  parameter int unsigned MAX_ROW_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] logit_value
  input  logic        in_tlast,    // row_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] probability
  output logic        out_tlast,   // last_of_row
  output logic [0:0]  out_tuser,   // [0] row_truncated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data     // beta_gain
);
  import rse_pkg::*;

  localparam int unsigned AW    = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ROW_LEN + 1);
  localparam int unsigned SUM_W = DATA_W + $clog2(MAX_ROW_LEN);

  typedef enum logic [7:0] {
    ST_LOAD   = 8'b0000_0001,
    ST_ERD    = 8'b0000_0010,
    ST_ESTART = 8'b0000_0100,
    ST_EWAIT  = 8'b0000_1000,
    ST_DRD    = 8'b0001_0000,
    ST_DSTART = 8'b0010_0000,
    ST_DWAIT  = 8'b0100_0000,
    ST_DPOST  = 8'b1000_0000
  } top_state_t;

  top_state_t               state_r, state_nxt;
  logic [DATA_W-1:0]        beta_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         idx_r;
  logic signed [DATA_W-1:0] max_r;
  logic [SUM_W-1:0]         sum_r;
  logic                     ovf_r;
  logic                     trunc_r;
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_data_r;
  logic                     out_last_r;
  logic                     out_user_r;

  logic [DATA_W-1:0]        logit_mem [MAX_ROW_LEN];
  logic [DATA_W-1:0]        exp_mem   [MAX_ROW_LEN];
  logic [DATA_W-1:0]        logit_q_r;
  logic [DATA_W-1:0]        exp_q_r;

  logic                     in_fire, room, is_last, out_free;
  logic signed [DATA_W-1:0] x_in;
  logic [DATA_W:0]          diff_w;
  logic                     exp_busy, div_busy;
  logic [DATA_W-1:0]        exp_val, prob;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_LOAD);
  assign cfg_ready = 1'b1;
  assign x_in      = $signed(in_tdata);
  assign room      = (count_r < CNT_W'(MAX_ROW_LEN));
  assign is_last   = (idx_r + CNT_W'(1) == count_r);
  assign out_free  = !out_valid_r || out_tready;
  assign diff_w    = {max_r[DATA_W-1], max_r} - {logit_q_r[DATA_W-1], logit_q_r};

  rse_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_ESTART),
    .diff    (diff_w[DATA_W-1:0]),
    .beta    (beta_r),
    .busy    (exp_busy),
    .exp_val (exp_val)
  );

  rse_div #(.SUM_W(SUM_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_DSTART),
    .exp_val (exp_q_r),
    .sum     (sum_r),
    .busy    (div_busy),
    .prob    (prob)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:   if (in_fire && in_tlast) state_nxt = ST_ERD;
      ST_ERD:    state_nxt = ST_ESTART;
      ST_ESTART: state_nxt = ST_EWAIT;
      ST_EWAIT:  if (!exp_busy) state_nxt = is_last ? ST_DRD : ST_ERD;
      ST_DRD:    state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT:  if (!div_busy) state_nxt = ST_DPOST;
      ST_DPOST:  if (out_free) state_nxt = is_last ? ST_LOAD : ST_DRD;
      default:   state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      beta_r      <= BETA_RESET;
      count_r     <= '0;
      idx_r       <= '0;
      max_r       <= MAX_RESET;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      trunc_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) beta_r <= cfg_data;
      if (state_r == ST_DPOST && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (room) begin
              count_r <= count_r + CNT_W'(1);
              if (x_in > max_r) max_r <= x_in;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_tlast) begin
              trunc_r <= ovf_r || !room;
              idx_r   <= '0;
              sum_r   <= '0;
            end
          end
        end
        ST_EWAIT: begin
          if (!exp_busy) begin
            sum_r <= sum_r + SUM_W'(exp_val);
            idx_r <= is_last ? '0 : idx_r + CNT_W'(1);
          end
        end
        ST_DPOST: begin
          if (out_free) begin
            if (is_last) begin
              count_r <= '0;
              max_r   <= MAX_RESET;
              ovf_r   <= 1'b0;
            end else begin
              idx_r <= idx_r + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DPOST && out_free) begin
      out_data_r <= prob;
      out_last_r <= is_last;
      out_user_r <= trunc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && room) logit_mem[count_r[AW-1:0]] <= in_tdata;
    if (state_r == ST_EWAIT && !exp_busy) exp_mem[idx_r[AW-1:0]] <= exp_val;
    logit_q_r <= logit_mem[idx_r[AW-1:0]];
    exp_q_r   <= exp_mem[idx_r[AW-1:0]];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(exp_busy && div_busy))
    else $error("exp unit and divider busy together");

  a_row_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after row end");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ROW_LEN))
    else $error("element count beyond capacity");

  a_last_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DPOST && out_free && is_last |=> in_tready && out_tlast)
    else $error("row end result not followed by reopened input");

endmodule
